// ----- rtl/jet_pkg.sv -----
// Shared types, constants and helpers for the Julia escape-time pipeline.
// Depends on nothing; every other file of the block imports it.
package jet_pkg;

	// Field widths fixed by the pixel and result formats.
	localparam int unsigned COORD_W = 10;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned STEP_W  = 31;
	localparam int unsigned INDEX_W = 3;

	// Iteration limit and nominal image size.
	localparam int unsigned ITER_LIMIT   = 64;
	localparam int unsigned IMAGE_WIDTH  = 1024;
	localparam int unsigned IMAGE_HEIGHT = 1024;

	// Q4.28 format and the escape radius squared, |z|^2 >= 4, in Q8.56.
	localparam int unsigned FRAC_BITS  = 28;
	localparam logic [63:0] ESCAPE_SQ  = 64'd4 << (2 * FRAC_BITS);

	// Signed width of 2*pixel - extent, enough for image sizes up to 4096.
	localparam int unsigned PIX_W  = 14;
	localparam int unsigned PROD_W = PIX_W + VAL_W;

	// Register stages: two in the start-point mapper, three per iteration.
	localparam int unsigned MAP_STAGES  = 2;
	localparam int unsigned ITER_STAGES = 3;
	localparam int unsigned PIPE_DEPTH  = MAP_STAGES + ITER_STAGES * ITER_LIMIT;

	// Configuration register indexes.
	localparam logic [INDEX_W-1:0] REG_CENTER_RE = 3'd0;
	localparam logic [INDEX_W-1:0] REG_CENTER_IM = 3'd1;
	localparam logic [INDEX_W-1:0] REG_STEP      = 3'd2;
	localparam logic [INDEX_W-1:0] REG_CONST_RE  = 3'd3;
	localparam logic [INDEX_W-1:0] REG_CONST_IM  = 3'd4;

	localparam logic [STEP_W-1:0] STEP_RESET = 31'd2097152;

	typedef struct packed {
		logic signed [VAL_W-1:0]  center_re;
		logic signed [VAL_W-1:0]  center_im;
		logic        [STEP_W-1:0] step;
		logic signed [VAL_W-1:0]  const_re;
		logic signed [VAL_W-1:0]  const_im;
	} jet_cfg_t;

	// One pixel in flight: current z, running count, and whether it is finished.
	typedef struct packed {
		logic signed [VAL_W-1:0]   zr;
		logic signed [VAL_W-1:0]   zi;
		logic        [COUNT_W-1:0] cnt;
		logic                      done;
	} jet_item_t;

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [47:0] v);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = 48'sd2147483647;
		lo = -48'sd2147483648;
		if (v > hi) begin
			return hi[VAL_W-1:0];
		end else if (v < lo) begin
			return lo[VAL_W-1:0];
		end else begin
			return v[VAL_W-1:0];
		end
	endfunction

endpackage

// ----- rtl/jet_pix_if.sv -----
// Pixel request channel: valid/ready handshake with column, row and start count.
// Depends on jet_pkg for the field widths.
interface jet_pix_if import jet_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] column;
	logic [COORD_W-1:0] row;
	logic [COUNT_W-1:0] start_count;

	modport source(output valid, column, row, start_count, input ready);
	modport sink(input valid, column, row, start_count, output ready);
endinterface

// ----- rtl/jet_res_if.sv -----
// Result channel: valid/ready handshake carrying the final iteration count.
// Depends on jet_pkg for the field width.
interface jet_res_if import jet_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] count;

	modport source(output valid, count, input ready);
	modport sink(input valid, count, output ready);
endinterface

// ----- rtl/jet_cfg_if.sv -----
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on jet_pkg for the index and data widths.
interface jet_cfg_if import jet_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] index;
	logic [VAL_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/julia_escape_time_top.sv -----
// Julia escape-time engine: an accepted pixel passes the mapper and then every
// iteration unit; one pixel per cycle while no result stalls, results in pixel order.
// Every iteration has its own three-stage multiply/test/update unit, so the chain
// length is set by ITER_LIMIT; a stall at the result freezes the whole chain.
// Reset (arst_n low, asynchronous) empties the pipeline and restores the registers.
// Depends on jet_pkg, the channel interfaces, jet_cfg, jet_map and jet_iter.
module julia_escape_time_top import jet_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	jet_pix_if.sink  pix,
	jet_res_if.source res,
	jet_cfg_if.sink  cfg
);

	jet_cfg_t  regs;
	logic      en;

	// Stage k of these arrays is the output of iteration unit k-1; entry 0 comes
	// from the start-point mapper.
	logic      chain_valid [ITER_LIMIT+1];
	jet_item_t chain_item  [ITER_LIMIT+1];

	// The chain moves as one: it advances whenever the final stage is empty or its
	// result is being transferred. The last stage register doubles as the output
	// register, so a new pixel is accepted in the same cycle a result leaves.
	assign en        = !chain_valid[ITER_LIMIT] || res.ready;
	assign pix.ready = en;

	jet_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Map the pixel onto the complex plane.
	jet_map u_map (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.regs        (regs),
		.in_valid    (pix.valid),
		.column      (pix.column),
		.row         (pix.row),
		.start_count (pix.start_count),
		.out_valid   (chain_valid[0]),
		.out_item    (chain_item[0])
	);

	// One unit per possible iteration. A pixel that has escaped or reached the limit
	// is carried through the remaining units unchanged.
	for (genvar k = 0; k < ITER_LIMIT; k++) begin : g_iter
		jet_iter u_iter (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.regs      (regs),
			.in_valid  (chain_valid[k]),
			.in_item   (chain_item[k]),
			.out_valid (chain_valid[k+1]),
			.out_item  (chain_item[k+1])
		);
	end

	assign res.valid = chain_valid[ITER_LIMIT];
	assign res.count = chain_item[ITER_LIMIT].cnt;

endmodule

// ----- rtl/jet_cfg.sv -----
// Configuration register file for the Julia pipeline.
// Depends on jet_pkg and jet_cfg_if.
module jet_cfg import jet_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	jet_cfg_if.sink   cfg,
	output jet_cfg_t  regs
);

	jet_cfg_t regs_q;

	// Writes are always taken; unknown indexes are dropped.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.center_re <= '0;
			regs_q.center_im <= '0;
			regs_q.step      <= STEP_RESET;
			regs_q.const_re  <= '0;
			regs_q.const_im  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_CENTER_RE: regs_q.center_re <= cfg.data;
				REG_CENTER_IM: regs_q.center_im <= cfg.data;
				REG_STEP:      regs_q.step      <= cfg.data[STEP_W-1:0];
				REG_CONST_RE:  regs_q.const_re  <= cfg.data;
				REG_CONST_IM:  regs_q.const_im  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/jet_map.sv -----
// Start-point mapper: turns a pixel index into the Q4.28 starting z in two stages.
// Depends on jet_pkg.
module jet_map import jet_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  jet_cfg_t           regs,
	input  logic               in_valid,
	input  logic [COORD_W-1:0] column,
	input  logic [COORD_W-1:0] row,
	input  logic [COUNT_W-1:0] start_count,
	output logic               out_valid,
	output jet_item_t          out_item
);

	logic signed [PIX_W-1:0]  dx;
	logic signed [PIX_W-1:0]  dy;
	logic signed [PROD_W-1:0] prod_re_s1;
	logic signed [PROD_W-1:0] prod_im_s1;
	logic        [COUNT_W-1:0] cnt_s1;
	logic                      valid_s1;
	logic signed [47:0]        sum_re;
	logic signed [47:0]        sum_im;
	jet_item_t                 item_s2;
	logic                      valid_s2;

	// 2*pixel - extent, so that the half-pixel offset stays exact.
	assign dx = PIX_W'({column, 1'b0}) - PIX_W'(IMAGE_WIDTH);
	assign dy = PIX_W'({row, 1'b0}) - PIX_W'(IMAGE_HEIGHT);

	// Stage 1: scale by the step.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_re_s1 <= dx * $signed({1'b0, regs.step});
			prod_im_s1 <= dy * $signed({1'b0, regs.step});
			cnt_s1     <= start_count;
		end
	end

	// Stage 2: add twice the center, halve with floor, saturate.
	assign sum_re = {{(48 - PROD_W){prod_re_s1[PROD_W-1]}}, prod_re_s1}
		+ {{(47 - VAL_W){regs.center_re[VAL_W-1]}}, regs.center_re, 1'b0};
	assign sum_im = {{(48 - PROD_W){prod_im_s1[PROD_W-1]}}, prod_im_s1}
		+ {{(47 - VAL_W){regs.center_im[VAL_W-1]}}, regs.center_im, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2.zr   <= sat32(sum_re >>> 1);
			item_s2.zi   <= sat32(sum_im >>> 1);
			item_s2.cnt  <= cnt_s1;
			item_s2.done <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

// ----- rtl/jet_iter.sv -----
// One z = z*z + c iteration in three stages: products, escape test, update.
// Depends on jet_pkg.
module jet_iter import jet_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  jet_cfg_t  regs,
	input  logic      in_valid,
	input  jet_item_t in_item,
	output logic      out_valid,
	output jet_item_t out_item
);

	logic signed [63:0] rr_s1;
	logic signed [63:0] ii_s1;
	logic signed [63:0] ri_s1;
	logic               active_s1;
	jet_item_t          item_s1;
	logic               valid_s1;

	logic signed [63:0] diff_s2;
	logic signed [63:0] ri_s2;
	logic               esc_s2;
	logic               active_s2;
	jet_item_t          item_s2;
	logic               valid_s2;

	logic [63:0]        mag;
	logic signed [47:0] new_re;
	logic signed [47:0] new_im;
	jet_item_t          item_s3;
	logic               valid_s3;

	// Stage 1: the three products. An item works only while unfinished and under the limit.
	always_ff @(posedge clk) begin
		if (en) begin
			rr_s1     <= in_item.zr * in_item.zr;
			ii_s1     <= in_item.zi * in_item.zi;
			ri_s1     <= in_item.zr * in_item.zi;
			active_s1 <= !in_item.done && ({25'd0, in_item.cnt} < ITER_LIMIT);
			item_s1   <= in_item;
		end
	end

	// Stage 2: escape test on |z|^2 and the real-part difference.
	assign mag = $unsigned(rr_s1) + $unsigned(ii_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			esc_s2    <= mag >= ESCAPE_SQ;
			diff_s2   <= rr_s1 - ii_s1;
			ri_s2     <= ri_s1;
			active_s2 <= active_s1;
			item_s2   <= item_s1;
		end
	end

	// Stage 3: floor-shift back to Q4.28, add c, saturate.
	assign new_re = {{12{diff_s2[63]}}, diff_s2[63:FRAC_BITS]}
		+ {{(48 - VAL_W){regs.const_re[VAL_W-1]}}, regs.const_re};
	assign new_im = {{11{ri_s2[63]}}, ri_s2[63:FRAC_BITS-1]}
		+ {{(48 - VAL_W){regs.const_im[VAL_W-1]}}, regs.const_im};

	always_ff @(posedge clk) begin
		if (en) begin
			if (active_s2 && !esc_s2) begin
				item_s3.zr   <= sat32(new_re);
				item_s3.zi   <= sat32(new_im);
				item_s3.cnt  <= item_s2.cnt + COUNT_W'(1);
				item_s3.done <= 1'b0;
			end else begin
				item_s3.zr   <= item_s2.zr;
				item_s3.zi   <= item_s2.zi;
				item_s3.cnt  <= item_s2.cnt;
				item_s3.done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

// ----- rtl/jet_checker.sv -----
// Port-level checker for the Julia escape-time engine, bound onto the top level.
// Depends on jet_pkg.
module jet_checker import jet_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               pix_valid,
	input logic               pix_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [COUNT_W-1:0] res_count
);

	localparam int unsigned OCC_W = $clog2(PIPE_DEPTH + 2);

	logic [OCC_W-1:0] occ_q;
	logic             pix_xfer;
	logic             res_xfer;

	assign pix_xfer = pix_valid && pix_ready;
	assign res_xfer = res_valid && res_ready;

	// Pixels accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (pix_xfer && !res_xfer) begin
			occ_q <= occ_q + OCC_W'(1);
		end else if (res_xfer && !pix_xfer) begin
			occ_q <= occ_q - OCC_W'(1);
		end
	end

	// The input side stalls exactly when a result is held back.
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		pix_ready == (!res_valid || res_ready))
		else $error("input ready does not follow the output stall");

	// No result without a pixel in flight.
	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (occ_q != '0))
		else $error("result shown with no pixel outstanding");

	// The chain cannot hold more pixels than it has stages.
	a_occupancy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(PIPE_DEPTH))
		else $error("more pixels in flight than pipeline stages");

	// A stalled result stays and keeps its value.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_count)))
		else $error("stalled result changed or dropped");

endmodule

bind julia_escape_time_top jet_checker u_jet_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_count (res.count)
);
